// File: sv/bilinear_rgb_sampler_unit_defines.svh
`ifndef BILINEAR_RGB_SAMPLER_UNIT_DEFINES_SVH
`define BILINEAR_RGB_SAMPLER_UNIT_DEFINES_SVH

// Both macros expect signals named clock and reset in the calling scope.
`define BRS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define BRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/brs_pkg.sv
`default_nettype none

package brs_pkg;

   localparam int MAX_WIDTH = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int FRAC_BITS = 8;

   localparam int DIM_W = 10;
   localparam int FIELD_POS_W = 9;
   localparam int CHAN_W = 8;
   localparam int NUM_CHANNELS = 3;
   localparam int PIXEL_W = NUM_CHANNELS * CHAN_W;
   localparam int SAMPLE_W = 17;
   localparam int INT_W = SAMPLE_W - FRAC_BITS;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int CMP_W = 24;

   localparam int WGT_W = FRAC_BITS + 1;
   localparam int TOP_W = CHAN_W + FRAC_BITS;
   localparam int SUM_W = CHAN_W + 2 * FRAC_BITS;

   localparam int NUM_BANKS = 4;
   localparam int BANK_SEL_W = 2;
   localparam int BANK_W = (MAX_WIDTH + 1) / 2;
   localparam int BANK_H = (MAX_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = BANK_W * BANK_H;
   localparam int BANK_AW = $clog2(BANK_DEPTH);

   localparam int APB_DW = 32;
   localparam int APB_AW = 3;
   localparam int REG_IDX_W = 1;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(512);
   localparam logic [REG_IDX_W-1:0] REG_ACTIVE_WIDTH = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_ACTIVE_HEIGHT = REG_IDX_W'(1);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(1) << FRAC_BITS;
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (2 * FRAC_BITS - 1);

   typedef struct packed {
      logic [COL_W-1:0] last_col;
      logic [ROW_W-1:0] last_row;
   } dims_type;

   typedef struct packed {
      logic                                sample;
      logic [NUM_BANKS-1:0]                wr_en;
      logic [NUM_BANKS-1:0][BANK_AW-1:0]   addr;
      logic [PIXEL_W-1:0]                  wdata;
      logic                                x1_odd;
      logic                                x2_odd;
      logic                                y1_odd;
      logic                                y2_odd;
      logic [FRAC_BITS-1:0]                fx;
      logic [WGT_W-1:0]                    wx;
      logic [FRAC_BITS-1:0]                fy;
      logic [WGT_W-1:0]                    wy;
   } fetch_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]   p00;
      logic [PIXEL_W-1:0]   p01;
      logic [PIXEL_W-1:0]   p10;
      logic [PIXEL_W-1:0]   p11;
      logic [FRAC_BITS-1:0] fx;
      logic [WGT_W-1:0]     wx;
      logic [FRAC_BITS-1:0] fy;
      logic [WGT_W-1:0]     wy;
   } blend_in_type;

   // Address of a pixel inside the bank that its column and row parity select.
   function automatic logic [BANK_AW-1:0] bank_addr(logic [COL_W-1:0] col,
                                                    logic [ROW_W-1:0] row);
      logic [CMP_W-1:0] col_half;
      logic [CMP_W-1:0] row_half;
      col_half = CMP_W'(col) >> 1;
      row_half = CMP_W'(row) >> 1;
      return BANK_AW'(row_half * CMP_W'(BANK_W) + col_half);
   endfunction

   // Channel 0 is red in the upper byte, channel 2 is blue in the lower byte.
   function automatic logic [CHAN_W-1:0] chan_of(logic [PIXEL_W-1:0] pix, int c);
      return pix[PIXEL_W - 1 - c * CHAN_W -: CHAN_W];
   endfunction

endpackage

`default_nettype wire

// File: sv/brs_req_if.sv
`default_nettype none

interface brs_req_if import brs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [FIELD_POS_W-1:0] pixel_col;
   logic [FIELD_POS_W-1:0] pixel_row;
   logic [CHAN_W-1:0]      in_red;
   logic [CHAN_W-1:0]      in_green;
   logic [CHAN_W-1:0]      in_blue;
   logic [SAMPLE_W-1:0]    sample_x;
   logic [SAMPLE_W-1:0]    sample_y;

   modport source (
      output valid, kind, pixel_col, pixel_row, in_red, in_green, in_blue,
             sample_x, sample_y,
      input  ready
   );

   modport sink (
      input  valid, kind, pixel_col, pixel_row, in_red, in_green, in_blue,
             sample_x, sample_y,
      output ready
   );
endinterface

`default_nettype wire

// File: sv/brs_rsp_if.sv
`default_nettype none

interface brs_rsp_if import brs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_red;
   logic [CHAN_W-1:0] out_green;
   logic [CHAN_W-1:0] out_blue;

   modport source (
      output valid, out_red, out_green, out_blue,
      input  ready
   );

   modport sink (
      input  valid, out_red, out_green, out_blue,
      output ready
   );
endinterface

`default_nettype wire

// File: sv/brs_bank_ram.sv
`default_nettype none

module brs_bank_ram #(
   parameter int DEPTH = 65536,
   parameter int ADDR_W = 16,
   parameter int DATA_W = 24
) (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wdata,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         if (wr_en) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: sv/brs_csr.sv
`default_nettype none

module brs_csr import brs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [APB_AW-1:0] paddr,
   input  wire logic [APB_DW-1:0] pwdata,
   output logic      [APB_DW-1:0] prdata,
   output logic                   pready,
   output dims_type               dims
);

   logic [DIM_W-1:0]     width_ff;
   logic [DIM_W-1:0]     width_in;
   logic [DIM_W-1:0]     height_ff;
   logic [DIM_W-1:0]     height_in;
   logic                 wr_hit;
   logic [REG_IDX_W-1:0] reg_idx;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite;
   assign reg_idx = paddr[APB_AW-1 -: REG_IDX_W];

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (wr_hit) begin
         unique case (reg_idx)
            REG_ACTIVE_WIDTH: begin
               width_in = pwdata[DIM_W-1:0];
            end
            REG_ACTIVE_HEIGHT: begin
               height_in = pwdata[DIM_W-1:0];
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ACTIVE_WIDTH: begin
            prdata = APB_DW'(width_ff);
         end
         REG_ACTIVE_HEIGHT: begin
            prdata = APB_DW'(height_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // A size of zero counts as one and a size above the store counts as the store size.
   always_comb begin
      if (width_ff == '0) begin
         dims.last_col = '0;
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         dims.last_col = COL_W'(MAX_WIDTH - 1);
      end else begin
         dims.last_col = COL_W'(width_ff - DIM_W'(1));
      end
      if (height_ff == '0) begin
         dims.last_row = '0;
      end else if (CMP_W'(height_ff) > CMP_W'(MAX_HEIGHT)) begin
         dims.last_row = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         dims.last_row = ROW_W'(height_ff - DIM_W'(1));
      end
   end

endmodule

`default_nettype wire

// File: sv/brs_coord.sv
`default_nettype none

module brs_coord import brs_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   brs_req_if.sink    req_bus,
   input  wire dims_type dims,
   output logic       out_valid,
   input  wire logic  out_ready,
   output fetch_type  out_data
);

   logic                   a_valid_ff;
   logic                   a_valid_in;
   logic                   a_kind_ff;
   logic [FIELD_POS_W-1:0] a_col_ff;
   logic [FIELD_POS_W-1:0] a_row_ff;
   logic [PIXEL_W-1:0]     a_pix_ff;
   logic [SAMPLE_W-1:0]    a_sx_ff;
   logic [SAMPLE_W-1:0]    a_sy_ff;
   logic                   ready_a;
   logic                   load_a;

   logic                   b_valid_ff;
   logic                   b_valid_in;
   fetch_type              b_data_ff;
   fetch_type              b_data_in;
   logic                   ready_b;
   logic                   load_b;

   logic [INT_W-1:0]       xi;
   logic [INT_W-1:0]       yi;
   logic [COL_W-1:0]       x1;
   logic [COL_W-1:0]       x2;
   logic [ROW_W-1:0]       y1;
   logic [ROW_W-1:0]       y2;
   logic [COL_W-1:0]       col_even;
   logic [COL_W-1:0]       col_odd;
   logic [ROW_W-1:0]       row_even;
   logic [ROW_W-1:0]       row_odd;
   logic [COL_W-1:0]       wcol;
   logic [ROW_W-1:0]       wrow;
   logic                   w_in_store;
   logic [BANK_SEL_W-1:0]  wbank;
   logic [BANK_AW-1:0]     waddr;

   assign ready_b = !b_valid_ff || out_ready;
   assign ready_a = !a_valid_ff || ready_b;
   assign load_a = ready_a && req_bus.valid;
   assign load_b = ready_b && a_valid_ff;
   assign a_valid_in = ready_a ? req_bus.valid : a_valid_ff;
   assign b_valid_in = ready_b ? a_valid_ff : b_valid_ff;
   assign req_bus.ready = ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         a_kind_ff <= req_bus.kind;
         a_col_ff <= req_bus.pixel_col;
         a_row_ff <= req_bus.pixel_row;
         a_pix_ff <= {req_bus.in_red, req_bus.in_green, req_bus.in_blue};
         a_sx_ff <= req_bus.sample_x;
         a_sy_ff <= req_bus.sample_y;
      end
      if (load_b) begin
         b_data_ff <= b_data_in;
      end
   end

   // Saturate the integer position, then clamp the right and lower neighbors.
   always_comb begin
      xi = a_sx_ff[SAMPLE_W-1:FRAC_BITS];
      yi = a_sy_ff[SAMPLE_W-1:FRAC_BITS];
      if (CMP_W'(xi) > CMP_W'(dims.last_col)) begin
         x1 = dims.last_col;
      end else begin
         x1 = COL_W'(xi);
      end
      if (CMP_W'(yi) > CMP_W'(dims.last_row)) begin
         y1 = dims.last_row;
      end else begin
         y1 = ROW_W'(yi);
      end
      x2 = (x1 < dims.last_col) ? x1 + COL_W'(1) : x1;
      y2 = (y1 < dims.last_row) ? y1 + ROW_W'(1) : y1;
      col_even = x1[0] ? x2 : x1;
      col_odd = x1[0] ? x1 : x2;
      row_even = y1[0] ? y2 : y1;
      row_odd = y1[0] ? y1 : y2;
   end

   always_comb begin
      wcol = COL_W'(a_col_ff);
      wrow = ROW_W'(a_row_ff);
      w_in_store = (CMP_W'(a_col_ff) < CMP_W'(MAX_WIDTH)) &&
                   (CMP_W'(a_row_ff) < CMP_W'(MAX_HEIGHT));
      wbank = {wrow[0], wcol[0]};
      waddr = bank_addr(wcol, wrow);
   end

   always_comb begin
      b_data_in.sample = (a_kind_ff == KIND_SAMPLE);
      b_data_in.wdata = a_pix_ff;
      for (int b = 0; b < NUM_BANKS; b++) begin
         if (a_kind_ff == KIND_SAMPLE) begin
            b_data_in.addr[b] = bank_addr(((b & 1) != 0) ? col_odd : col_even,
                                          ((b & 2) != 0) ? row_odd : row_even);
            b_data_in.wr_en[b] = 1'b0;
         end else begin
            b_data_in.addr[b] = waddr;
            b_data_in.wr_en[b] = w_in_store && (wbank == BANK_SEL_W'(b));
         end
      end
      b_data_in.x1_odd = x1[0];
      b_data_in.x2_odd = x2[0];
      b_data_in.y1_odd = y1[0];
      b_data_in.y2_odd = y2[0];
      b_data_in.fx = a_sx_ff[FRAC_BITS-1:0];
      b_data_in.fy = a_sy_ff[FRAC_BITS-1:0];
      b_data_in.wx = WEIGHT_ONE - WGT_W'(a_sx_ff[FRAC_BITS-1:0]);
      b_data_in.wy = WEIGHT_ONE - WGT_W'(a_sy_ff[FRAC_BITS-1:0]);
   end

   assign out_valid = b_valid_ff;
   assign out_data = b_data_ff;

endmodule

`default_nettype wire

// File: sv/brs_fetch.sv
`default_nettype none
`include "bilinear_rgb_sampler_unit_defines.svh"

module brs_fetch import brs_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   output logic        in_ready,
   input  wire fetch_type in_data,
   output logic        out_valid,
   input  wire logic   out_ready,
   output blend_in_type out_data
);

   logic                              c_valid_ff;
   logic                              c_valid_in;
   logic                              c_x1_odd_ff;
   logic                              c_x2_odd_ff;
   logic                              c_y1_odd_ff;
   logic                              c_y2_odd_ff;
   logic [FRAC_BITS-1:0]              c_fx_ff;
   logic [WGT_W-1:0]                  c_wx_ff;
   logic [FRAC_BITS-1:0]              c_fy_ff;
   logic [WGT_W-1:0]                  c_wy_ff;
   logic                              load;
   logic [NUM_BANKS-1:0][PIXEL_W-1:0] rdata;

   assign in_ready = !c_valid_ff || out_ready;
   assign load = in_valid && in_ready;
   // Pixel writes end here; only samples travel on.
   assign c_valid_in = in_ready ? (in_valid && in_data.sample) : c_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         c_x1_odd_ff <= in_data.x1_odd;
         c_x2_odd_ff <= in_data.x2_odd;
         c_y1_odd_ff <= in_data.y1_odd;
         c_y2_odd_ff <= in_data.y2_odd;
         c_fx_ff <= in_data.fx;
         c_wx_ff <= in_data.wx;
         c_fy_ff <= in_data.fy;
         c_wy_ff <= in_data.wy;
      end
   end

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      brs_bank_ram #(
         .DEPTH  (BANK_DEPTH),
         .ADDR_W (BANK_AW),
         .DATA_W (PIXEL_W)
      ) u_bank (
         .clock  (clock),
         .enable (load),
         .wr_en  (in_data.wr_en[b]),
         .addr   (in_data.addr[b]),
         .wdata  (in_data.wdata),
         .rdata  (rdata[b])
      );
   end

   always_comb begin
      out_data.p00 = rdata[{c_y1_odd_ff, c_x1_odd_ff}];
      out_data.p01 = rdata[{c_y1_odd_ff, c_x2_odd_ff}];
      out_data.p10 = rdata[{c_y2_odd_ff, c_x1_odd_ff}];
      out_data.p11 = rdata[{c_y2_odd_ff, c_x2_odd_ff}];
      out_data.fx = c_fx_ff;
      out_data.wx = c_wx_ff;
      out_data.fy = c_fy_ff;
      out_data.wy = c_wy_ff;
   end

   assign out_valid = c_valid_ff;

   `BRS_ASSERT_NOW(a_one_bank_written, load, $onehot0(in_data.wr_en), "several banks written")
   `BRS_ASSERT_NOW(a_sample_never_writes, in_valid && in_data.sample, in_data.wr_en == '0, "sample request writes a bank")
   `BRS_ASSERT_NEXT(a_write_gives_no_result, load && !in_data.sample, !c_valid_ff, "pixel write produced a result")
   `BRS_ASSERT_NEXT(a_held_read_data, c_valid_ff && !out_ready, $stable(rdata), "read data lost while stalled")

endmodule

`default_nettype wire

// File: sv/brs_blend.sv
`default_nettype none

module brs_blend import brs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire blend_in_type in_data,
   brs_rsp_if.source    rsp_bus
);

   logic                 d_valid_ff;
   logic                 d_valid_in;
   logic [TOP_W-1:0]     top_ff [NUM_CHANNELS];
   logic [TOP_W-1:0]     top_in [NUM_CHANNELS];
   logic [TOP_W-1:0]     bot_ff [NUM_CHANNELS];
   logic [TOP_W-1:0]     bot_in [NUM_CHANNELS];
   logic [FRAC_BITS-1:0] d_fy_ff;
   logic [WGT_W-1:0]     d_wy_ff;
   logic                 ready_d;
   logic                 load_d;

   logic                 e_valid_ff;
   logic                 e_valid_in;
   logic [SUM_W-1:0]     sum [NUM_CHANNELS];
   logic [CHAN_W-1:0]    res_ff [NUM_CHANNELS];
   logic [CHAN_W-1:0]    res_in [NUM_CHANNELS];
   logic                 ready_e;
   logic                 load_e;

   assign ready_e = !e_valid_ff || rsp_bus.ready;
   assign ready_d = !d_valid_ff || ready_e;
   assign in_ready = ready_d;
   assign load_d = ready_d && in_valid;
   assign load_e = ready_e && d_valid_ff;
   assign d_valid_in = ready_d ? in_valid : d_valid_ff;
   assign e_valid_in = ready_e ? d_valid_ff : e_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= d_valid_in;
         e_valid_ff <= e_valid_in;
      end
   end

   // Horizontal blend of the upper and lower pixel pairs.
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         top_in[c] = TOP_W'(chan_of(in_data.p00, c)) * TOP_W'(in_data.wx) +
                     TOP_W'(chan_of(in_data.p01, c)) * TOP_W'(in_data.fx);
         bot_in[c] = TOP_W'(chan_of(in_data.p10, c)) * TOP_W'(in_data.wx) +
                     TOP_W'(chan_of(in_data.p11, c)) * TOP_W'(in_data.fx);
      end
   end

   always_ff @(posedge clock) begin
      if (load_d) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         d_fy_ff <= in_data.fy;
         d_wy_ff <= in_data.wy;
      end
   end

   // Vertical blend, then round half up to the channel width.
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         sum[c] = SUM_W'(top_ff[c]) * SUM_W'(d_wy_ff) +
                  SUM_W'(bot_ff[c]) * SUM_W'(d_fy_ff) + ROUND_HALF;
         res_in[c] = sum[c][SUM_W-1 -: CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (load_e) begin
         res_ff <= res_in;
      end
   end

   assign rsp_bus.valid = e_valid_ff;
   assign rsp_bus.out_red = res_ff[0];
   assign rsp_bus.out_green = res_ff[1];
   assign rsp_bus.out_blue = res_ff[2];

endmodule

`default_nettype wire

// File: sv/bilinear_rgb_sampler_unit.sv
// Bilinear RGB888 sampler. Requests of kind write load one source pixel into a
// 512 x 512 pixel store; requests of kind sample return one interpolated RGB888
// pixel at an unsigned position with 8 fraction bits, and writes return nothing.
// It takes one request per clock while the output is not stalled, writes and
// samples mixed in any order; a sample's result passes the coordinate, fetch
// and blend registers to the output register. The pixel store sets the rate;
// it is split into four single-port banks by column and row parity, so that a
// sample's four neighbors are read in the same cycle, one per bank. Unwritten
// pixels read as undefined data; the store has no clear after reset. The user
// changes the active width and height registers at byte addresses 0 and 4 only
// while no request is in flight; the block does not enforce it. 0 counts as 1.
`default_nettype none

module bilinear_rgb_sampler_unit import brs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   brs_req_if.sink                req_bus,
   brs_rsp_if.source              rsp_bus,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [APB_AW-1:0] paddr,
   input  wire logic [APB_DW-1:0] pwdata,
   output logic      [APB_DW-1:0] prdata,
   output logic                   pready
);

   dims_type     dims;
   logic         fetch_valid;
   logic         fetch_ready;
   fetch_type    fetch_data;
   logic         blend_valid;
   logic         blend_ready;
   blend_in_type blend_data;

   brs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .dims    (dims)
   );

   brs_coord u_coord (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .dims      (dims),
      .out_valid (fetch_valid),
      .out_ready (fetch_ready),
      .out_data  (fetch_data)
   );

   brs_fetch u_fetch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fetch_valid),
      .in_ready  (fetch_ready),
      .in_data   (fetch_data),
      .out_valid (blend_valid),
      .out_ready (blend_ready),
      .out_data  (blend_data)
   );

   brs_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .in_valid (blend_valid),
      .in_ready (blend_ready),
      .in_data  (blend_data),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire
